// ----- rtl/multi_channel_soft_timer_bank_core_assert.svh -----
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Property wrappers used by the timer bank core module.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_CORE_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCSTB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Next-cycle implication, checked outside reset.
`define MCSTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

// ----- rtl/mcstb_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer bank package
// Types, codes and defaults shared by the timer bank modules.
// ----------------------------------------------------------------------------
package mcstb_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int TIME_BITS_DEF = 32;
    localparam int WAIT_W        = 31;

    localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 31'h7fffffff;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_RESUME = 3'd5;
    localparam logic [2:0] OP_STATUS = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [1:0] KIND_EXPIRY = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_CMD    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  channel;
        logic [31:0] delay;
        logic [31:0] interval;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        chan_out;
        logic              is_active;
        logic              is_running;
        logic [WAIT_W-1:0] next_wait;
        logic              last;
    } t_out;

    // Command broadcast to every cell; hit marks the addressed cell.
    typedef struct packed {
        logic        hit;
        logic [2:0]  op;
        logic [31:0] delay;
        logic [31:0] interval;
    } t_cmd;

    // What one cell hands to its neighbor along the walk.
    typedef struct packed {
        logic              token;
        logic [WAIT_W-1:0] wait_min;
    } t_link;

endpackage

// ----- rtl/mcstb_cell.sv -----
// ----------------------------------------------------------------------------
// Timer bank cell
// Holds one channel and processes it in registered steps when the walk token passes.
// ----------------------------------------------------------------------------
module mcstb_cell #(
    parameter int TIME_BITS = mcstb_pkg::TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mcstb_pkg::t_cmd            i_cmd,
    input  logic                       i_activate,
    input  logic [TIME_BITS-1:0]       i_now,
    input  logic [mcstb_pkg::WAIT_W-1:0] i_max_wait,
    input  mcstb_pkg::t_link           i_prev,
    output mcstb_pkg::t_link           o_next,
    output logic                       o_expired,
    output logic                       o_active,
    output logic                       o_running
);
    import mcstb_pkg::*;

    localparam int CW = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;

    logic                 r_active, n_active;
    logic                 r_add, n_add;
    logic                 r_run, n_run;
    logic                 r_start, n_start;
    logic                 r_stop, n_stop;
    logic                 r_remove, n_remove;
    logic [TIME_BITS-1:0] r_period, n_period;
    logic [TIME_BITS-1:0] r_left, n_left;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic                 r_phb, n_phb;
    t_link                r_link, n_link;

    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] start_dl;
    logic [TIME_BITS-2:0] wait_cand;
    logic                 cand_ok;
    logic                 due;

    always_comb begin
        diff      = r_deadline - i_now;
        start_dl  = r_left + i_now;
        due       = r_run && (diff[TIME_BITS-1] || (diff == '0));
        o_expired = i_prev.token && r_active && !r_remove && due;
    end

    always_comb begin
        n_active   = r_active;
        n_add      = r_add;
        n_run      = r_run;
        n_start    = r_start;
        n_stop     = r_stop;
        n_remove   = r_remove;
        n_period   = r_period;
        n_left     = r_left;
        n_deadline = r_deadline;
        n_phb      = 1'b0;
        n_link     = r_link;
        n_link.token = 1'b0;
        wait_cand  = '0;
        cand_ok    = 1'b0;

        if (i_cmd.hit) begin
            unique case (i_cmd.op)
                OP_ADD: begin
                    n_active   = 1'b0;
                    n_run      = 1'b0;
                    n_start    = 1'b0;
                    n_stop     = 1'b0;
                    n_remove   = 1'b0;
                    n_left     = '0;
                    n_deadline = '0;
                    n_period   = i_cmd.interval[TIME_BITS-1:0];
                    n_add      = 1'b1;
                end
                OP_REMOVE: n_remove = 1'b1;
                OP_START: begin
                    n_left  = i_cmd.delay[TIME_BITS-1:0];
                    n_start = 1'b1;
                end
                OP_STOP:   n_stop  = 1'b1;
                OP_RESUME: n_start = 1'b1;
                default: ;
            endcase
        end

        // Pending adds go live at the tick, clamped to the maximum wait.
        if (i_activate && r_add) begin
            if (CW'(r_period) > CW'(i_max_wait)) n_period = TIME_BITS'(i_max_wait);
            if (CW'(r_left) > CW'(i_max_wait))   n_left   = TIME_BITS'(i_max_wait);
            n_active = 1'b1;
            n_add    = 1'b0;
        end

        // First walk cycle: remove, then expiry with reload (or stop for a one-shot).
        if (i_prev.token) begin
            n_phb = 1'b1;
            n_link.wait_min = i_prev.wait_min;
            if (r_active) begin
                if (r_remove) begin
                    n_active   = 1'b0;
                    n_run      = 1'b0;
                    n_start    = 1'b0;
                    n_stop     = 1'b0;
                    n_remove   = 1'b0;
                    n_left     = '0;
                    n_deadline = '0;
                    n_period   = '0;
                end else if (due) begin
                    if (r_period != '0) begin
                        n_deadline = r_deadline + r_period;
                    end else begin
                        n_deadline = '0;
                        n_run      = 1'b0;
                    end
                end
            end
        end

        // Second walk cycle: start, stop and the wait contribution.
        if (r_phb) begin
            n_link.token = 1'b1;
            if (r_active) begin
                priority if (r_start && r_stop) begin
                    n_left     = r_left[TIME_BITS-1] ? '0 : r_left;
                    n_deadline = '0;
                    n_run      = 1'b0;
                    n_start    = 1'b0;
                    n_stop     = 1'b0;
                end else if (r_start) begin
                    n_deadline = start_dl;
                    n_run      = 1'b1;
                    n_start    = 1'b0;
                    cand_ok    = 1'b1;
                    wait_cand  = r_left[TIME_BITS-1] ? '0 : r_left[TIME_BITS-2:0];
                end else if (r_stop) begin
                    if (r_run) n_left = diff[TIME_BITS-1] ? '0 : diff;
                    n_deadline = '0;
                    n_run      = 1'b0;
                    n_stop     = 1'b0;
                end else begin
                    cand_ok   = r_run;
                    wait_cand = diff[TIME_BITS-1] ? '0 : diff[TIME_BITS-2:0];
                end
                if (cand_ok && (WAIT_W'(wait_cand) < r_link.wait_min)) begin
                    n_link.wait_min = WAIT_W'(wait_cand);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_add      <= 1'b0;
            r_run      <= 1'b0;
            r_start    <= 1'b0;
            r_stop     <= 1'b0;
            r_remove   <= 1'b0;
            r_period   <= '0;
            r_left     <= '0;
            r_deadline <= '0;
            r_phb      <= 1'b0;
            r_link     <= '0;
        end else begin
            r_active   <= n_active;
            r_add      <= n_add;
            r_run      <= n_run;
            r_start    <= n_start;
            r_stop     <= n_stop;
            r_remove   <= n_remove;
            r_period   <= n_period;
            r_left     <= n_left;
            r_deadline <= n_deadline;
            r_phb      <= n_phb;
            r_link     <= n_link;
        end
    end

    assign o_next    = r_link;
    assign o_active  = r_active;
    assign o_running = r_run;

endmodule

// ----- rtl/multi_channel_soft_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// Multi-channel soft timer bank
// Command-driven bank of periodic and one-shot timer channels.
// ----------------------------------------------------------------------------
// A command (add, remove, start, stop, resume) is answered by one
// command-accepted transaction in the following cycle; a status query is
// answered the same way. For a tick, each channel lives in a cell of a
// chain, and a walk token passes through every cell in registered steps
// (expiry, then start/stop and the wait minimum), so the walk length is
// set by the cell chain. While the walk runs, busy is high.
// Expiry transactions come out while the walk runs, in channel order, and
// the walk-done transaction with the nearest wait ends the tick. Results
// are presented for exactly one cycle on o_strobe; the receiver cannot
// stall them, so it must take every strobed transaction.
module multi_channel_soft_timer_bank_core #(
    parameter int CHANNELS  = mcstb_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = mcstb_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  mcstb_pkg::t_in               i_cmd,
    output logic                         o_strobe,
    output mcstb_pkg::t_out              o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mcstb_pkg::WAIT_W-1:0] i_cfg_data
);
    import mcstb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [WAIT_W-1:0]    r_max_wait;
    logic                 r_tok, n_tok;
    logic                 r_strobe, n_strobe;
    t_out                 r_res, n_res;

    t_cmd                 cmd [CHANNELS];
    t_link                links [CHANNELS+1];
    logic [CHANNELS-1:0]  exp_v;
    logic [CHANNELS-1:0]  act_v;
    logic [CHANNELS-1:0]  run_v;
    logic [CHANNELS-1:0]  tok_v;

    logic                 accept;
    logic                 in_range;
    logic                 is_tick;
    logic [2:0]           exp_idx;
    logic                 st_act;
    logic                 st_run;

    assign busy        = (r_state == S_WALK);
    assign accept      = start && !busy;
    assign is_tick     = accept && (i_cmd.op == OP_TICK);
    assign in_range    = (32'(i_cmd.channel) < 32'(CHANNELS));
    assign o_cfg_ready = !busy;

    // The walk token enters the first cell in the cycle after the tick is accepted.
    assign links[0].token    = r_tok;
    assign links[0].wait_min = r_max_wait;

    for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
        always_comb begin
            cmd[k].hit      = accept && (32'(i_cmd.channel) == 32'(k));
            cmd[k].op       = i_cmd.op;
            cmd[k].delay    = i_cmd.delay;
            cmd[k].interval = i_cmd.interval;
        end

        mcstb_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd[k]),
            .i_activate (is_tick),
            .i_now      (r_now),
            .i_max_wait (r_max_wait),
            .i_prev     (links[k]),
            .o_next     (links[k+1]),
            .o_expired  (exp_v[k]),
            .o_active   (act_v[k]),
            .o_running  (run_v[k])
        );

        assign tok_v[k] = links[k].token;
    end

    // Only the cell holding the token can flag an expiry, so an OR of
    // indices gives the expired channel.
    always_comb begin
        exp_idx = '0;
        st_act  = 1'b0;
        st_run  = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (exp_v[k]) exp_idx = exp_idx | 3'(k);
            if (32'(i_cmd.channel) == 32'(k)) begin
                st_act = act_v[k];
                st_run = run_v[k];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_tok    = 1'b0;
        n_strobe = 1'b0;
        n_res    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            n_now   = r_now + 1'b1;
                            n_tok   = 1'b1;
                            n_state = S_WALK;
                        end
                        OP_ADD, OP_REMOVE, OP_START, OP_STOP, OP_RESUME: begin
                            n_strobe       = 1'b1;
                            n_res.kind     = KIND_CMD;
                            n_res.chan_out = i_cmd.channel;
                            n_res.last     = 1'b1;
                        end
                        OP_STATUS: begin
                            n_strobe         = 1'b1;
                            n_res.kind       = KIND_STATUS;
                            n_res.chan_out   = i_cmd.channel;
                            n_res.is_active  = in_range && st_act;
                            n_res.is_running = in_range && st_run;
                            n_res.last       = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (|exp_v) begin
                    n_strobe       = 1'b1;
                    n_res.kind     = KIND_EXPIRY;
                    n_res.chan_out = exp_idx;
                end
                if (links[CHANNELS].token) begin
                    n_strobe        = 1'b1;
                    n_res.kind      = KIND_DONE;
                    n_res.next_wait = links[CHANNELS].wait_min;
                    n_res.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_now      <= '0;
            r_max_wait <= MAX_WAIT_RST;
            r_tok      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_tok    <= n_tok;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) r_max_wait <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `include "multi_channel_soft_timer_bank_core_assert.svh"

    // At most one cell holds the walk token.
    `MCSTB_ASSERT_SAME(a_token_single, 1'b1, $onehot0(tok_v))
    // The walk token only moves while the bank is busy.
    `MCSTB_ASSERT_SAME(a_token_busy, |tok_v, busy)
    // A walk-done transaction always closes the tick.
    `MCSTB_ASSERT_SAME(a_done_last, o_strobe && (o_result.kind == KIND_DONE), o_result.last)
    // An accepted command is answered in the next cycle.
    `MCSTB_ASSERT_NEXT(a_cmd_answer,
        accept && (i_cmd.op != OP_TICK) && (i_cmd.op != OP_UNUSED), o_strobe && o_result.last)

endmodule

// ----- bench/multi_channel_soft_timer_bank_core_test.sv -----
// ----------------------------------------------------------------------------
// Timer bank core testbench
// Drives commands, ticks and max_wait writes into the timer bank. A built-in
// timer model predicts every result, and the scoreboard compares each
// strobed transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_core_test;
    import mcstb_pkg::*;

    localparam int NCH        = 8;
    localparam int WALK_CYC   = 2 * NCH + 2;
    localparam int CYCLE_CAP  = 400000;

    // The scoreboard holds its own copy of the timer state and predicts
    // the results of every accepted transaction.
    class timer_scoreboard;
        logic [30:0] max_wait;
        logic [31:0] now_t;
        logic        act[NCH], addp[NCH], run[NCH];
        logic        strq[NCH], stpq[NCH], remq[NCH];
        logic [31:0] per[NCH], left[NCH], dl[NCH];
        t_out        expected_q[$];
        int          errors;

        function new();
            max_wait = MAX_WAIT_RST;
            now_t = '0;
            errors = 0;
            for (int c = 0; c < NCH; c++) begin
                wipe(c);
                per[c] = '0;
            end
        endfunction

        function void wipe(int c);
            act[c] = 0; addp[c] = 0; run[c] = 0;
            strq[c] = 0; stpq[c] = 0; remq[c] = 0;
            left[c] = '0; dl[c] = '0;
        endfunction

        function void push(logic [1:0] k, logic [2:0] ch, logic a, logic r,
                           logic [30:0] w, logic l);
            t_out o;
            o.kind = k; o.chan_out = ch; o.is_active = a;
            o.is_running = r; o.next_wait = w; o.last = l;
            expected_q.push_back(o);
        endfunction

        // Remaining ticks until the deadline, floored at zero.
        function logic [31:0] remaining(int c);
            logic signed [31:0] d;
            d = $signed(dl[c] - now_t);
            return (d < 0) ? 32'd0 : d;
        endfunction

        function void walk();
            logic [31:0] best;
            logic signed [31:0] d;
            best = {1'b0, max_wait};
            now_t = now_t + 32'd1;
            for (int c = 0; c < NCH; c++) begin
                if (addp[c]) begin
                    if (per[c] > {1'b0, max_wait}) per[c] = {1'b0, max_wait};
                    if (left[c] > {1'b0, max_wait}) left[c] = {1'b0, max_wait};
                    act[c] = 1;
                    addp[c] = 0;
                end
            end
            for (int c = 0; c < NCH; c++) begin
                if (!act[c]) continue;
                if (remq[c]) begin
                    wipe(c);
                    per[c] = '0;
                    continue;
                end
                d = $signed(dl[c] - now_t);
                if (run[c] && d <= 0) begin
                    push(KIND_EXPIRY, c[2:0], 0, 0, '0, 0);
                    if (per[c] != 0) dl[c] = dl[c] + per[c];
                    else begin
                        dl[c] = '0;
                        run[c] = 0;
                    end
                end
                if (strq[c]) begin
                    dl[c] = left[c] + now_t;
                    run[c] = 1;
                    strq[c] = 0;
                end
                if (stpq[c]) begin
                    if (run[c]) left[c] = remaining(c);
                    dl[c] = '0;
                    run[c] = 0;
                    stpq[c] = 0;
                end
                if (run[c] && remaining(c) < best) best = remaining(c);
            end
            push(KIND_DONE, '0, 0, 0, best[30:0], 1);
        endfunction

        // Called for each transaction the block accepts.
        function void note_cmd(t_in x);
            int c;
            c = int'(x.channel);
            case (x.op)
                OP_TICK: begin
                    walk();
                    return;
                end
                OP_ADD: begin
                    wipe(c);
                    per[c] = x.interval;
                    addp[c] = 1;
                end
                OP_REMOVE: remq[c] = 1;
                OP_START: begin
                    left[c] = x.delay;
                    strq[c] = 1;
                end
                OP_STOP:   stpq[c] = 1;
                OP_RESUME: strq[c] = 1;
                OP_STATUS: begin
                    push(KIND_STATUS, x.channel, act[c], run[c], '0, 1);
                    return;
                end
                default: return;
            endcase
            push(KIND_CMD, x.channel, 0, 0, '0, 1);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            $display("mismatch %s: got %0h expected %0h", what, got, exp);
            errors++;
        endtask

        task check_result(t_out o);
            t_out e;
            if (expected_q.size() == 0) begin
                report("unexpected result", 32'(o.kind), 32'd0);
                return;
            end
            e = expected_q.pop_front();
            if (o.kind != e.kind) report("kind", 32'(o.kind), 32'(e.kind));
            if (o.chan_out != e.chan_out)
                report("chan_out", 32'(o.chan_out), 32'(e.chan_out));
            if (o.is_active != e.is_active)
                report("is_active", 32'(o.is_active), 32'(e.is_active));
            if (o.is_running != e.is_running)
                report("is_running", 32'(o.is_running), 32'(e.is_running));
            if (o.next_wait != e.next_wait)
                report("next_wait", 32'(o.next_wait), 32'(e.next_wait));
            if (o.last != e.last) report("last", 32'(o.last), 32'(e.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_in         i_cmd = '0;
    logic        o_strobe;
    t_out        o_result;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data = '0;

    timer_scoreboard sb = new();
    int cycles = 0;

    multi_channel_soft_timer_bank_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL multi_channel_soft_timer_bank_core");
            $finish;
        end
    end

    // Results cannot be held off, so every strobed cycle is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one command and hold it until accepted; start stays high
    // when the next command follows without a gap.
    task send_cmd(t_in x);
        int g;
        start <= 1;
        i_cmd <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(x);
        g = gap_len();
        if (g > 0) begin
            start <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task send(logic [2:0] op, logic [2:0] ch, logic [31:0] dly, logic [31:0] intv);
        t_in x;
        x.op = op; x.channel = ch; x.delay = dly; x.interval = intv;
        send_cmd(x);
    endtask

    // Writes max_wait once the bank is idle and all results are in.
    task write_max_wait(logic [30:0] v);
        start <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (WALK_CYC + 6) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.max_wait = v;
        i_cfg_valid <= 0;
    endtask

    function logic [31:0] rand_span();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hffffffff;
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    task random_phase(int n);
        int r;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) op = OP_TICK;
            else if (r < 52) op = OP_ADD;
            else if (r < 66) op = OP_START;
            else if (r < 73) op = OP_STOP;
            else if (r < 80) op = OP_RESUME;
            else if (r < 85) op = OP_REMOVE;
            else if (r < 98) op = OP_STATUS;
            else op = OP_UNUSED;
            send(op, 3'($urandom_range(0, 7)), rand_span(), rand_span());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: periodic and one-shot channels, overrun, stop and
        // resume, remove, commands on inactive channels, unused op, extremes.
        send(OP_STATUS, 3'd0, '0, '0);
        send(OP_START, 3'd5, 32'd1, '0);
        send(OP_ADD, 3'd0, '0, 32'd3);
        send(OP_START, 3'd0, 32'd2, '0);
        send(OP_ADD, 3'd7, '0, 32'd0);
        send(OP_START, 3'd7, 32'd0, '0);
        send(OP_ADD, 3'd3, '0, 32'hffffffff);
        send(OP_START, 3'd3, 32'hffffffff, '0);
        send(OP_TICK, '0, 32'hffffffff, 32'hffffffff);
        send(OP_TICK, 3'd7, '0, '0);
        send(OP_STATUS, 3'd7, '0, '0);
        send(OP_TICK, '0, '0, '0);
        send(OP_STOP, 3'd0, '0, '0);
        send(OP_TICK, '0, '0, '0);
        send(OP_STATUS, 3'd0, '0, '0);
        send(OP_RESUME, 3'd0, '0, '0);
        send(OP_TICK, '0, '0, '0);
        send(OP_STOP, 3'd4, '0, '0);
        send(OP_REMOVE, 3'd3, '0, '0);
        send(OP_UNUSED, 3'd2, 32'h5a5a5a5a, 32'ha5a5a5a5);
        send(OP_TICK, '0, '0, '0);
        send(OP_STATUS, 3'd3, '0, '0);
        repeat (4) send(OP_TICK, '0, '0, '0);

        write_max_wait(31'd1);
        random_phase(50);
        write_max_wait(31'd0);
        random_phase(30);
        write_max_wait(31'd6);
        random_phase(40);
        write_max_wait(31'($urandom()));
        random_phase(40);
        write_max_wait(31'h7fffffff);
        random_phase(70);

        start <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (WALK_CYC + 10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS multi_channel_soft_timer_bank_core");
        else
            $display("FAIL multi_channel_soft_timer_bank_core");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mcstb_pkg.sv
rtl/mcstb_cell.sv
rtl/multi_channel_soft_timer_bank_core.sv
bench/multi_channel_soft_timer_bank_core_test.sv
